@@ rtl/dtfp_pkg.sv @@
package dtfp_pkg;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int WHOLE_W  = 63;
    localparam int FRAC_W   = 7;
    localparam int AMOUNT_W = 64;
    localparam int STATUS_W = 2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_PARSE = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // Overflow limits: (2^63-1 - d) / 10 and (2^63-1 - f) / 100 are these values
    // when the low digit d or fraction f is at most seven, and one less above that.
    localparam logic [WHOLE_W-1:0] WHOLE_STEP_LIMIT = 63'd922337203685477580;
    localparam logic [WHOLE_W-1:0] FINISH_LIMIT     = 63'd92233720368547758;
    localparam logic [FRAC_W-1:0]  LIMIT_LOW_MAX    = 7'd7;

    // Snapshot of the parser state at a terminator
    typedef struct packed {
        status_t              status;
        logic                 neg;
        logic [WHOLE_W-1:0]   whole;
        logic [FRAC_W-1:0]    frac;
    } fin_t;

endpackage

@@ rtl/dtfp_parse.sv @@
module dtfp_parse
    import dtfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              char_valid,
    output logic              char_stall,
    output logic              fin_valid,
    output fin_t              fin,
    input  logic              take_ready
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_WHOLE,
        PH_POINT,
        PH_FRAC1,
        PH_FRAC2,
        PH_TRAIL
    } phase_t;

    logic              chr_valid_reg;
    logic [CHAR_W-1:0] chr_reg;

    phase_t             phase_reg,  phase_next;
    logic [WHOLE_W-1:0] whole_reg,  whole_next;
    logic [FRAC_W-1:0]  frac_reg,   frac_next;
    logic               neg_reg,    neg_next;
    logic               seen_reg,   seen_next;
    status_t            err_reg,    err_next;

    logic    fin_valid_reg;
    fin_t    fin_reg;
    status_t fin_status;

    logic               is_term, is_ws, is_dig, is_sign, is_point;
    logic               fin_ready, consume;
    logic [3:0]         digit;
    logic [WHOLE_W-1:0] whole_times_ten;
    logic               whole_over, finish_over;

    // Classify the held character
    assign is_term  = (chr_reg == CH_NUL);
    assign is_ws    = (chr_reg == CH_SPACE) || ((chr_reg >= CH_TAB) && (chr_reg <= CH_CR));
    assign is_dig   = (chr_reg >= CH_ZERO) && (chr_reg <= CH_NINE);
    assign is_sign  = (chr_reg == CH_PLUS) || (chr_reg == CH_MINUS);
    assign is_point = (chr_reg == CH_POINT);
    assign digit    = chr_reg[3:0];

    // Handshake: a terminator needs room in the snapshot register
    assign fin_ready  = !fin_valid_reg || take_ready;
    assign consume    = chr_valid_reg && (!is_term || fin_ready);
    assign char_stall = chr_valid_reg && !consume;

    // Whole accumulation and its overflow test
    assign whole_times_ten = {whole_reg[WHOLE_W-4:0], 3'b000}
                           + {whole_reg[WHOLE_W-2:0], 1'b0}
                           + WHOLE_W'(digit);
    assign whole_over = (whole_reg > WHOLE_STEP_LIMIT)
                     || ((whole_reg == WHOLE_STEP_LIMIT) && (FRAC_W'(digit) > LIMIT_LOW_MAX));
    assign finish_over = (whole_reg > FINISH_LIMIT)
                      || ((whole_reg == FINISH_LIMIT) && (frac_reg > LIMIT_LOW_MAX));

    // Final status at a terminator
    always_comb
    begin
        fin_status = err_reg;
        if (err_reg == ST_OK)
        begin
            if ((phase_reg == PH_LEAD) || (phase_reg == PH_SIGN) || !seen_reg)
                fin_status = ST_PARSE;
            else if (finish_over)
                fin_status = ST_OVER;
        end
    end

    // Advance the parser by one character
    always_comb
    begin
        phase_next = phase_reg;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        if (consume)
        begin
            if (is_term)
            begin
                phase_next = PH_LEAD;
                whole_next = '0;
                frac_next  = '0;
                neg_next   = 1'b0;
                seen_next  = 1'b0;
                err_next   = ST_OK;
            end
            else if (err_reg == ST_OK)
            begin
                unique case (phase_reg) inside
                    PH_LEAD, PH_SIGN:
                    begin
                        if ((phase_reg == PH_LEAD) && is_ws)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if ((phase_reg == PH_LEAD) && is_sign)
                        begin
                            neg_next   = (chr_reg == CH_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (is_dig)
                        begin
                            whole_next = WHOLE_W'(digit);
                            seen_next  = 1'b1;
                            phase_next = PH_WHOLE;
                        end
                        else if (is_point)
                            phase_next = PH_POINT;
                        else
                            err_next = ST_PARSE;
                    end
                    PH_WHOLE:
                    begin
                        if (is_dig)
                        begin
                            if (whole_over)
                                err_next = ST_OVER;
                            else
                                whole_next = whole_times_ten;
                        end
                        else if (is_point)
                            phase_next = PH_POINT;
                        else if (is_ws)
                            phase_next = PH_TRAIL;
                        else
                            err_next = ST_PARSE;
                    end
                    PH_POINT:
                    begin
                        if (is_dig)
                        begin
                            frac_next  = {digit, 3'b000} + {2'b00, digit, 1'b0};
                            seen_next  = 1'b1;
                            phase_next = PH_FRAC1;
                        end
                        else if (is_ws)
                            phase_next = PH_TRAIL;
                        else
                            err_next = ST_PARSE;
                    end
                    PH_FRAC1:
                    begin
                        if (is_dig)
                        begin
                            frac_next  = frac_reg + FRAC_W'(digit);
                            seen_next  = 1'b1;
                            phase_next = PH_FRAC2;
                        end
                        else if (is_ws)
                            phase_next = PH_TRAIL;
                        else
                            err_next = ST_PARSE;
                    end
                    PH_FRAC2:
                    begin
                        if (is_ws && !is_dig)
                            phase_next = PH_TRAIL;
                        else
                            err_next = ST_PARSE;
                    end
                    default:
                    begin
                        if (!is_ws)
                            err_next = ST_PARSE;
                    end
                endcase
            end
        end
    end

    // Hold the input character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chr_valid_reg <= 1'b0;
        else if (!char_stall)
            chr_valid_reg <= char_valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
            chr_reg <= char_code;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            whole_reg <= '0;
            frac_reg  <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            err_reg   <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            whole_reg <= whole_next;
            frac_reg  <= frac_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
        end
    end

    // Snapshot at a terminator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (fin_ready)
            fin_valid_reg <= consume && is_term;
    end

    always_ff @(posedge clk)
    begin
        if (consume && is_term)
        begin
            fin_reg.status <= fin_status;
            fin_reg.neg    <= neg_reg;
            fin_reg.whole  <= whole_reg;
            fin_reg.frac   <= frac_reg;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule

@@ rtl/dtfp_scale.sv @@
module dtfp_scale
    import dtfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fin_valid,
    input  fin_t                fin,
    output logic                take_ready,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [STATUS_W-1:0] status,
    output logic [AMOUNT_W-1:0] amount
);

    logic                scl_valid_reg;
    status_t             scl_status_reg;
    logic                scl_neg_reg;
    logic [AMOUNT_W-1:0] scl_value_reg, scl_value_next;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [AMOUNT_W-1:0] amount_reg, amount_next;

    logic out_ready;

    // Ready chain through the two stages
    assign out_ready  = !out_valid_reg || !result_stall;
    assign take_ready = !scl_valid_reg || out_ready;

    // Scale to hundredths: whole * 64 + whole * 32 + whole * 4 + fraction
    assign scl_value_next = {fin.whole[AMOUNT_W-7:0], 6'b000000}
                          + {fin.whole[AMOUNT_W-6:0], 5'b00000}
                          + {fin.whole[AMOUNT_W-3:0], 2'b00}
                          + AMOUNT_W'(fin.frac);

    // Apply sign; drop the value on any error
    always_comb
    begin
        if (scl_status_reg != ST_OK)
            amount_next = '0;
        else if (scl_neg_reg)
            amount_next = ~scl_value_reg + AMOUNT_W'(1);
        else
            amount_next = scl_value_reg;
    end

    // Scale stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scl_valid_reg <= 1'b0;
        else if (take_ready)
            scl_valid_reg <= fin_valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_ready && fin_valid)
        begin
            scl_status_reg <= fin.status;
            scl_neg_reg    <= fin.neg;
            scl_value_reg  <= scl_value_next;
        end
    end

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= scl_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && scl_valid_reg)
        begin
            status_reg <= scl_status_reg;
            amount_reg <= amount_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign amount       = amount_reg;

endmodule

@@ rtl/decimal_text_to_fixed_point_core.sv @@
// A terminator passes the character, snapshot, scale and output registers to a result.
// Throughput: one character per cycle while char_stall is low.
// Non-terminator characters give no result; each terminator gives exactly one.
// Reset (rst_n low, asynchronous) clears all valids and returns the parser
// to the leading-whitespace phase with no error latched.
module decimal_text_to_fixed_point_core
    import dtfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic                char_valid,
    output logic                char_stall,
    output logic [STATUS_W-1:0] status,
    output logic [AMOUNT_W-1:0] amount,
    output logic                result_valid,
    input  logic                result_stall
);

    logic fin_valid;
    fin_t fin;
    logic take_ready;

    // Character parser and terminator snapshot
    dtfp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_code),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .fin_valid  (fin_valid),
        .fin        (fin),
        .take_ready (take_ready)
    );

    // Scale, sign and output register
    dtfp_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .fin_valid    (fin_valid),
        .fin          (fin),
        .take_ready   (take_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .amount       (amount)
    );

endmodule

@@ rtl/dtfp_checker.sv @@
module dtfp_checker
    import dtfp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic [CHAR_W-1:0]   char_code,
    input logic                char_valid,
    input logic                char_stall,
    input logic [STATUS_W-1:0] status,
    input logic [AMOUNT_W-1:0] amount,
    input logic                result_valid,
    input logic                result_stall
);

    // Hold a stalled character
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_code))
        else $error("stalled character changed");

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status) && $stable(amount))
        else $error("stalled result changed");

    // Zero amount on any error
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> (amount == '0))
        else $error("nonzero amount with error status");

    // Only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == ST_OK) || (status == ST_PARSE) || (status == ST_OVER))
        else $error("undefined status code");

    // No result once a reset cycle has passed
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result valid during reset");

endmodule

bind decimal_text_to_fixed_point_core dtfp_checker u_dtfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_code    (char_code),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .status       (status),
    .amount       (amount),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
